// ===== rtl/sha1_stream_hasher_core_defines.svh =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core_defines
// Assertion macros used by the SHA-1 stream hasher checker.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA1_STREAM_HASHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define SHA1SH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1sh: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define SHA1SH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1sh: next-cycle check failed");

`endif

// ===== rtl/sha1sh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Types, constants and command/status structs of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

    // Default width of the bit length kept for the padding trailer
    localparam int LENGTH_BITS_DEF = 64;
    // Width of the length trailer in the last block
    localparam int LEN_FIELD_BITS  = 64;

    typedef logic [5:0]  t_fill;
    typedef logic [6:0]  t_round;
    typedef logic [4:0]  t_out_cnt;
    typedef logic [31:0] t_word;

    // Block fill points
    localparam t_fill FILL_LAST = 6'd63;
    localparam t_fill LEN_START = 6'd56;

    // Round counter points
    localparam t_round ROUND_LAST  = 7'd79;
    localparam t_round ROUND_SEG_1 = 7'd20;
    localparam t_round ROUND_SEG_2 = 7'd40;
    localparam t_round ROUND_SEG_3 = 7'd60;

    // Last digest byte index
    localparam t_out_cnt DIGEST_LAST = 5'd19;

    // Padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Round constants
    localparam t_word K_SEG_0 = 32'h5a827999;
    localparam t_word K_SEG_1 = 32'h6ed9eba1;
    localparam t_word K_SEG_2 = 32'h8f1bbcdc;
    localparam t_word K_SEG_3 = 32'hca62c1d6;

    // Initial chaining values
    localparam t_word INIT_H0 = 32'h67452301;
    localparam t_word INIT_H1 = 32'hefcdab89;
    localparam t_word INIT_H2 = 32'h98badcfe;
    localparam t_word INIT_H3 = 32'h10325476;
    localparam t_word INIT_H4 = 32'hc3d2e1f0;

    // Channel payloads
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_msg_item;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic       last_byte;
    } t_dig_item;

    // Source of a byte written into the block
    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_ROUND,
        S_FOLD
    } t_ctrl_state;

    // Controller to datapath
    typedef struct packed {
        logic      insert;
        t_byte_sel byte_sel;
        logic      count_byte;
        logic      latch_len;
        logic      round;
        logic      fold;
        logic      finalize;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_fill fill;
        logic  round_last;
        logic  out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/sha1sh_stream_if.sv =====
// ----------------------------------------------------------------------------
// sha1sh_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1sh_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/sha1sh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1sh_ctrl
// Sequencer: byte intake, padding, round loop and chain fold.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_ctrl
    import sha1sh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_mode,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_ctrl_state r_state, n_state;
    logic        r_fin, n_fin;
    logic        r_len_done, n_len_done;
    logic        w_take;

    assign w_take = i_in_valid && o_in_ready;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fin      <= 1'b0;
            r_len_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fin      <= n_fin;
            r_len_done <= n_len_done;
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_fin      = r_fin;
        n_len_done = r_len_done;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && i_in_mode) begin
                    n_state = S_PAD_MARK;
                    n_fin   = 1'b1;
                end else if (w_take && (i_status.fill == FILL_LAST)) begin
                    n_state = S_ROUND;
                end
            end
            S_PAD_MARK: begin
                n_state = (i_status.fill == FILL_LAST) ? S_ROUND : S_PAD_ZERO;
            end
            S_PAD_ZERO: begin
                if (i_status.fill == LEN_START) begin
                    n_state = S_PAD_LEN;
                end else if (i_status.fill == FILL_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_PAD_LEN: begin
                if (i_status.fill == FILL_LAST) begin
                    n_state    = S_ROUND;
                    n_len_done = 1'b1;
                end
            end
            S_ROUND: begin
                if (i_status.round_last) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (r_fin && r_len_done) begin
                    n_state    = S_IDLE;
                    n_fin      = 1'b0;
                    n_len_done = 1'b0;
                end else if (r_fin) begin
                    n_state = S_PAD_ZERO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.insert     = 1'b0;
        o_cmd.byte_sel   = SEL_DATA;
        o_cmd.count_byte = 1'b0;
        o_cmd.latch_len  = 1'b0;
        o_cmd.round      = 1'b0;
        o_cmd.fold       = 1'b0;
        o_cmd.finalize   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // A finish waits until the previous digest has gone out
                o_in_ready       = !i_in_mode || !i_status.out_busy;
                o_cmd.insert     = w_take && !i_in_mode;
                o_cmd.count_byte = w_take && !i_in_mode;
                o_cmd.latch_len  = w_take && i_in_mode;
            end
            S_PAD_MARK: begin
                o_cmd.insert   = 1'b1;
                o_cmd.byte_sel = SEL_MARK;
            end
            S_PAD_ZERO: begin
                o_cmd.insert   = (i_status.fill != LEN_START);
                o_cmd.byte_sel = SEL_ZERO;
            end
            S_PAD_LEN: begin
                o_cmd.insert   = 1'b1;
                o_cmd.byte_sel = SEL_LEN;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
            end
            S_FOLD: begin
                o_cmd.fold     = 1'b1;
                o_cmd.finalize = r_fin && r_len_done;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sha1sh_dp.sv =====
// ----------------------------------------------------------------------------
// sha1sh_dp
// Block gathering, message schedule, round unit, chaining words and digest out.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_dp
    import sha1sh_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_out_ready,
    output t_dp_status      o_status,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    // Byte gathering and schedule window (holds W[t] .. W[t+15])
    logic [23:0]            r_word_acc;
    t_word                  r_sched [16];
    t_fill                  r_fill;
    logic [60:0]            r_msg_count;
    logic [LENGTH_BITS-1:0] r_bit_len;

    // Rounds and chaining
    t_word                  r_work  [5];
    t_word                  r_chain [5];
    t_round                 r_round;

    // Digest output register
    logic [159:0]           r_digest;
    logic                   r_out_valid;
    t_out_cnt               r_out_cnt;

    logic [7:0]                w_byte;
    logic [LEN_FIELD_BITS-1:0] w_len_field;
    logic [63:0]               w_bit_len_full;
    t_word                     w_f, w_k, w_new_w, w_temp;
    t_word                     w_sum [5];
    logic                      w_block_done;
    logic                      w_out_take;

    assign w_bit_len_full = {r_msg_count, 3'b000};
    assign w_len_field    = LEN_FIELD_BITS'(r_bit_len);
    assign w_block_done   = i_cmd.insert && (r_fill == FILL_LAST);
    assign w_out_take     = r_out_valid && i_out_ready;

    // Pick the byte written into the block
    always_comb begin
        case (i_cmd.byte_sel)
            SEL_DATA: w_byte = i_data_byte;
            SEL_MARK: w_byte = PAD_MARK;
            SEL_ZERO: w_byte = 8'h00;
            SEL_LEN:  w_byte = w_len_field[{~r_fill[2:0], 3'b000} +: 8];
            default:  w_byte = 8'h00;
        endcase
    end

    // Round function, constant and schedule expansion
    always_comb begin
        if (r_round < ROUND_SEG_1) begin
            w_f = (r_work[1] & r_work[2]) | (~r_work[1] & r_work[3]);
            w_k = K_SEG_0;
        end else if (r_round < ROUND_SEG_2) begin
            w_f = r_work[1] ^ r_work[2] ^ r_work[3];
            w_k = K_SEG_1;
        end else if (r_round < ROUND_SEG_3) begin
            w_f = (r_work[1] & r_work[2]) | (r_work[1] & r_work[3]) |
                  (r_work[2] & r_work[3]);
            w_k = K_SEG_2;
        end else begin
            w_f = r_work[1] ^ r_work[2] ^ r_work[3];
            w_k = K_SEG_3;
        end
        w_new_w = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
        w_new_w = {w_new_w[30:0], w_new_w[31]};
        w_temp  = {r_work[0][26:0], r_work[0][31:27]} + w_f + r_work[4] + w_k + r_sched[0];
    end

    // Chain plus working words
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_sum[i] = r_chain[i] + r_work[i];
        end
    end

    // Gather bytes into words and shift the schedule window
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            if (r_fill[1:0] == 2'b11) begin
                for (int i = 0; i < 15; i++) begin
                    r_sched[i] <= r_sched[i+1];
                end
                r_sched[15] <= {r_word_acc, w_byte};
            end else begin
                r_word_acc <= {r_word_acc[15:0], w_byte};
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_sched[i] <= r_sched[i+1];
            end
            r_sched[15] <= w_new_w;
        end
    end

    // Latch the bit length when a finish arrives
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_len) begin
            r_bit_len <= w_bit_len_full[LENGTH_BITS-1:0];
        end
    end

    // Load working words at block start, advance one round a cycle
    always_ff @(posedge i_clk) begin
        if (w_block_done) begin
            for (int i = 0; i < 5; i++) begin
                r_work[i] <= r_chain[i];
            end
        end else if (i_cmd.round) begin
            r_work[4] <= r_work[3];
            r_work[3] <= r_work[2];
            r_work[2] <= {r_work[1][1:0], r_work[1][31:2]};
            r_work[1] <= r_work[0];
            r_work[0] <= w_temp;
        end
    end

    // Digest shift register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fold && i_cmd.finalize) begin
            r_digest <= {w_sum[0], w_sum[1], w_sum[2], w_sum[3], w_sum[4]};
        end else if (w_out_take) begin
            r_digest <= {r_digest[151:0], 8'h00};
        end
    end

    // Control state: fill, counts, rounds, chain and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_msg_count <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
            r_out_cnt   <= '0;
            r_chain[0]  <= INIT_H0;
            r_chain[1]  <= INIT_H1;
            r_chain[2]  <= INIT_H2;
            r_chain[3]  <= INIT_H3;
            r_chain[4]  <= INIT_H4;
        end else begin
            if (i_cmd.insert) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.count_byte) begin
                r_msg_count <= r_msg_count + 61'd1;
            end
            if (w_block_done) begin
                r_round <= '0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 7'd1;
            end
            if (i_cmd.fold) begin
                if (i_cmd.finalize) begin
                    // Return to the initial state for the next message
                    r_chain[0]  <= INIT_H0;
                    r_chain[1]  <= INIT_H1;
                    r_chain[2]  <= INIT_H2;
                    r_chain[3]  <= INIT_H3;
                    r_chain[4]  <= INIT_H4;
                    r_msg_count <= '0;
                end else begin
                    for (int i = 0; i < 5; i++) begin
                        r_chain[i] <= w_sum[i];
                    end
                end
            end
            if (i_cmd.fold && i_cmd.finalize) begin
                r_out_valid <= 1'b1;
                r_out_cnt   <= '0;
            end else if (w_out_take) begin
                r_out_cnt <= r_out_cnt + 5'd1;
                if (r_out_cnt == DIGEST_LAST) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_status.fill       = r_fill;
    assign o_status.round_last = (r_round == ROUND_LAST);
    assign o_status.out_busy   = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_digest[159:152];
    assign o_out_last  = (r_out_cnt == DIGEST_LAST);

endmodule

`default_nettype wire

// ===== rtl/sha1_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// Streaming SHA-1 hasher: message bytes in, 20 digest bytes out per finish.
// ----------------------------------------------------------------------------
//  channel  dir  request carries               handshake
//  i_msg    in   mode, data_byte               valid/ready
//  o_dig    out  digest_byte, last_byte        valid/ready
//
//  A data byte is written into the current 64-byte block; the byte that fills
//  a block starts a compression of 80 rounds on the single round unit plus
//  the chain fold, and no further byte is taken until the fold is done.
//  A finish writes the padding into the block and runs one or two more
//  compressions before the digest bytes appear, one per cycle when taken.
//  Reset is synchronous and active low; no clearing pass follows it.
//  A stalled digest does not block data bytes; a further finish waits until
//  the last digest byte has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher_core
    import sha1sh_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sha1sh_stream_if.sink   i_msg,
    sha1sh_stream_if.source o_dig
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;
    logic [7:0] w_out_byte;
    logic       w_out_last;

    // Sequencer
    sha1sh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_msg.valid),
        .i_in_mode  (i_msg.payload.mode),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath
    sha1sh_dp #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_byte (i_msg.payload.data_byte),
        .i_out_ready (o_dig.ready),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .o_out_byte  (w_out_byte),
        .o_out_last  (w_out_last)
    );

    assign i_msg.ready               = w_in_ready;
    assign o_dig.valid               = w_out_valid;
    assign o_dig.payload.digest_byte = w_out_byte;
    assign o_dig.payload.last_byte   = w_out_last;

endmodule

`default_nettype wire

// ===== rtl/sha1sh_checker.sv =====
// ----------------------------------------------------------------------------
// sha1sh_checker
// Port-level checks of the SHA-1 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_stream_hasher_core_defines.svh"

module sha1sh_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_mode,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    // A finish is never taken while a digest is still going out
    `SHA1SH_ASSERT_SAME(a_fin_waits, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_mode, !i_out_valid)
    // Digest bytes keep coming until the last one
    `SHA1SH_ASSERT_NEXT(a_dig_runs, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, i_out_valid)
    // Output drops after the last digest byte
    `SHA1SH_ASSERT_NEXT(a_dig_ends, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_last, !i_out_valid)
    // Hold a stalled digest byte
    `SHA1SH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last))

endmodule

bind sha1_stream_hasher_core sha1sh_checker u_sha1sh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_msg.valid),
    .i_in_ready  (i_msg.ready),
    .i_in_mode   (i_msg.payload.mode),
    .i_out_valid (o_dig.valid),
    .i_out_ready (o_dig.ready),
    .i_out_byte  (o_dig.payload.digest_byte),
    .i_out_last  (o_dig.payload.last_byte)
);

`default_nettype wire
